FILE: rtl/plnsm_pkg.sv
package plnsm_pkg;

    localparam int TIME_W        = 32;
    localparam int PEER_IDX_W    = 8;
    localparam int STATE_W       = 3;
    localparam int ACTIVE_W      = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int PEER_SLOTS_DEF = 16;

    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX   = 5'd31;
    localparam logic [TIME_W-1:0]   WINDOW_RST   = 32'd5000;
    localparam logic [TIME_W-1:0]   INTERVAL_RST = 32'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_NET_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT     = 2'd3;

    localparam logic CMD_PEER_SEEN = 1'b0;
    localparam logic CMD_TICK      = 1'b1;

    typedef enum logic [STATE_W-1:0] {
        MODE_INIT     = 3'd0,
        MODE_ACTIVE   = 3'd1,
        MODE_SYNCING  = 3'd2,
        MODE_ISOLATED = 3'd3,
        MODE_DEGRADED = 3'd4
    } node_mode_t;

    typedef struct packed {
        logic ready;
        logic capture;
        logic scan_start;
        logic scan_rd;
        logic ps_rd;
        logic ps_wr;
        logic step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_valid;
        logic is_tick;
        logic in_range;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: rtl/plnsm_ifs.sv
interface plnsm_item_if;
    import plnsm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [TIME_W-1:0]     now_ms;
    logic [PEER_IDX_W-1:0] peer_index;
    logic                  degraded;

    modport source (output valid, cmd, now_ms, peer_index, degraded, input ready);
    modport sink   (input valid, cmd, now_ms, peer_index, degraded, output ready);
endinterface

interface plnsm_result_if;
    import plnsm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATE_W-1:0]  node_state;
    logic [ACTIVE_W-1:0] active_peers;
    logic                synced;
    logic                quorum_degraded;
    logic [TIME_W-1:0]   isolation_count;
    logic [TIME_W-1:0]   sync_count;

    modport source (output valid, node_state, active_peers, synced, quorum_degraded,
                    isolation_count, sync_count, input ready);
    modport sink   (input valid, node_state, active_peers, synced, quorum_degraded,
                    isolation_count, sync_count, output ready);
endinterface

FILE: rtl/peer_liveness_node_state_monitor.sv
// tick transaction: S_SCAN reads one peer table entry per slot, then S_DRAIN, then S_STEP
//   loads the result once the output register is free; a new item is taken only in idle
// peer-seen transaction: read-modify-write of one table entry in S_PS_READ and S_PS_WRITE,
//   then S_EMIT; out-of-range peer: straight to S_EMIT; both wait for a free result slot
// reset (rst_n, asynchronous): control, configuration, counters and slot valid marks
//   cleared at once; table contents need no clearing pass
module peer_liveness_node_state_monitor
#(
    parameter int PEER_SLOTS = plnsm_pkg::PEER_SLOTS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [plnsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plnsm_pkg::CFG_DATA_W-1:0] cfg_data,
    plnsm_item_if.sink                       item,
    plnsm_result_if.source                   result
);
    import plnsm_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    plnsm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    plnsm_dp #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .result    (result),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item taken while a transaction is in progress");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.emit) |-> sts.out_free)
        else $error("result register overwritten");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.scan_rd, cmd.ps_rd, cmd.ps_wr, cmd.step, cmd.emit}))
        else $error("conflicting datapath commands");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.step || cmd.emit))
        else $error("result without a load");
`endif

endmodule

FILE: rtl/plnsm_ctrl.sv
module plnsm_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  plnsm_pkg::ctrl_sts_t  sts,
    output plnsm_pkg::ctrl_cmd_t  cmd
);
    import plnsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_STEP,
        S_PS_READ,
        S_PS_WRITE,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.item_valid)
                begin
                    cmd.capture = 1'b1;
                    if (sts.is_tick)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else if (sts.in_range)
                    begin
                        state_next = S_PS_READ;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sts.out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PS_READ:
            begin
                cmd.ps_rd  = 1'b1;
                state_next = S_PS_WRITE;
            end
            S_PS_WRITE:
            begin
                cmd.ps_wr  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/plnsm_dp.sv
module plnsm_dp
#(
    parameter int PEER_SLOTS = plnsm_pkg::PEER_SLOTS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [plnsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plnsm_pkg::CFG_DATA_W-1:0]    cfg_data,
    plnsm_item_if.sink                          item,
    plnsm_result_if.source                      result,
    input  plnsm_pkg::ctrl_cmd_t                cmd,
    output plnsm_pkg::ctrl_sts_t                sts
);
    import plnsm_pkg::*;

    localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int CNT_W = $clog2(PEER_SLOTS + 1);
    localparam int Q_W   = CNT_W + 2;
    localparam logic [IDX_W-1:0]      SCAN_LAST = IDX_W'(PEER_SLOTS - 1);
    localparam logic [PEER_IDX_W:0]   SLOTS_EXT = (PEER_IDX_W + 1)'(PEER_SLOTS);
    localparam int MEM_W = TIME_W + 1;

    // configuration
    logic              net_en_reg;
    logic [TIME_W-1:0] window_reg;
    logic [TIME_W-1:0] interval_reg;
    logic [TIME_W-1:0] boot_reg;

    // captured transaction
    logic [TIME_W-1:0]     now_reg;
    logic [PEER_IDX_W-1:0] idx_reg;
    logic                  deg_reg;

    // peer table
    logic [MEM_W-1:0]      mem [PEER_SLOTS];
    logic [PEER_SLOTS-1:0] valid_reg;
    logic [MEM_W-1:0]      rd_data_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      ps_addr;

    // scan
    logic [IDX_W-1:0]    scan_cnt_reg;
    logic                chk_reg;
    logic [ACTIVE_W-1:0] live_reg;
    logic [TIME_W-1:0]   age;

    // node state
    node_mode_t          mode_reg;
    node_mode_t          mode_next;
    logic [ACTIVE_W-1:0] active_reg;
    logic [TIME_W-1:0]   last_sync_reg;
    logic [TIME_W-1:0]   iso_reg;
    logic [TIME_W-1:0]   sync_reg;
    logic [CNT_W-1:0]    known_reg;
    logic [CNT_W-1:0]    bad_reg;

    // step logic
    logic              hello;
    logic              iso_cond;
    logic              iso_inc;
    logic              periodic;
    logic [TIME_W-1:0] last_eff;
    logic [TIME_W-1:0] since_boot;
    logic [TIME_W-1:0] since_sync;
    logic              quorum;
    logic [Q_W-1:0]    bad_x3;
    logic [Q_W-1:0]    known_x2;
    logic              old_deg;

    // output register
    logic                out_valid_reg;
    logic [STATE_W-1:0]  out_state_reg;
    logic [ACTIVE_W-1:0] out_active_reg;
    logic                out_synced_reg;
    logic                out_quorum_reg;
    logic [TIME_W-1:0]   out_iso_reg;
    logic [TIME_W-1:0]   out_sync_reg;

    assign item.ready = cmd.ready;

    assign sts.item_valid = item.valid;
    assign sts.is_tick    = (item.cmd == CMD_TICK);
    assign sts.in_range   = ({1'b0, item.peer_index} < SLOTS_EXT);
    assign sts.scan_last  = (scan_cnt_reg == SCAN_LAST);
    assign sts.out_free   = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_en_reg   <= 1'b0;
            window_reg   <= WINDOW_RST;
            interval_reg <= INTERVAL_RST;
            boot_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NET_EN:   net_en_reg   <= cfg_data[0];
                CFG_WINDOW:   window_reg   <= cfg_data[TIME_W-1:0];
                CFG_INTERVAL: interval_reg <= cfg_data[TIME_W-1:0];
                CFG_BOOT:     boot_reg     <= cfg_data[TIME_W-1:0];
                default:      net_en_reg   <= net_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg  <= item.now_ms;
            idx_reg  <= item.peer_index;
            deg_reg  <= item.degraded;
        end
    end

    assign ps_addr = idx_reg[IDX_W-1:0];
    assign rd_addr = cmd.ps_rd ? ps_addr : scan_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ps_rd || cmd.scan_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ps_wr)
        begin
            mem[ps_addr] <= {deg_reg, now_reg};
        end
    end

    assign old_deg = rd_vld_reg && rd_data_reg[TIME_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            known_reg  <= '0;
            bad_reg    <= '0;
        end
        else
        begin
            if (cmd.ps_rd || cmd.scan_rd)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (cmd.ps_wr)
            begin
                valid_reg[ps_addr] <= 1'b1;
                if (!rd_vld_reg)
                begin
                    known_reg <= known_reg + CNT_W'(1);
                end
                if (old_deg && !deg_reg)
                begin
                    bad_reg <= bad_reg - CNT_W'(1);
                end
                else if (!old_deg && deg_reg)
                begin
                    bad_reg <= bad_reg + CNT_W'(1);
                end
            end
        end
    end

    assign age = now_reg - rd_data_reg[TIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            chk_reg      <= 1'b0;
            live_reg     <= '0;
        end
        else
        begin
            chk_reg <= cmd.scan_rd;
            if (cmd.scan_start)
            begin
                scan_cnt_reg <= '0;
                live_reg     <= '0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                end
                if (chk_reg && rd_vld_reg && (age < window_reg) && (live_reg != ACTIVE_MAX))
                begin
                    live_reg <= live_reg + ACTIVE_W'(1);
                end
            end
        end
    end

    // node machine and periodic sync
    assign since_boot = now_reg - boot_reg;
    assign iso_cond   = (live_reg == '0) && (since_boot > window_reg);
    assign hello      = (mode_reg == MODE_INIT) && net_en_reg;
    assign iso_inc    = (mode_reg != MODE_INIT) && iso_cond && (mode_reg != MODE_ISOLATED);
    assign last_eff   = hello ? now_reg : last_sync_reg;
    assign since_sync = now_reg - last_eff;
    assign periodic   = net_en_reg && (since_sync >= interval_reg);

    always_comb
    begin
        mode_next = mode_reg;
        if (mode_reg == MODE_INIT)
        begin
            mode_next = net_en_reg ? MODE_SYNCING : MODE_ACTIVE;
        end
        else if (iso_cond)
        begin
            mode_next = MODE_ISOLATED;
        end
        else if (deg_reg)
        begin
            mode_next = MODE_DEGRADED;
        end
        else if (live_reg != '0)
        begin
            mode_next = MODE_ACTIVE;
        end
    end

    assign bad_x3   = Q_W'(bad_reg) + Q_W'({bad_reg, 1'b0});
    assign known_x2 = Q_W'({known_reg, 1'b0});
    assign quorum   = (known_reg != '0) && (bad_x3 >= known_x2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_INIT;
            active_reg    <= '0;
            last_sync_reg <= '0;
            iso_reg       <= '0;
            sync_reg      <= '0;
        end
        else if (cmd.step)
        begin
            mode_reg   <= mode_next;
            active_reg <= live_reg;
            if (hello || periodic)
            begin
                last_sync_reg <= now_reg;
            end
            if (iso_inc)
            begin
                iso_reg <= iso_reg + TIME_W'(1);
            end
            sync_reg <= sync_reg + TIME_W'(hello) + TIME_W'(periodic);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step || cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_state_reg  <= STATE_W'(mode_next);
            out_active_reg <= live_reg;
            out_synced_reg <= periodic;
            out_quorum_reg <= quorum;
            out_iso_reg    <= iso_inc ? iso_reg + TIME_W'(1) : iso_reg;
            out_sync_reg   <= sync_reg + TIME_W'(hello) + TIME_W'(periodic);
        end
        else if (cmd.emit)
        begin
            out_state_reg  <= STATE_W'(mode_reg);
            out_active_reg <= active_reg;
            out_synced_reg <= 1'b0;
            out_quorum_reg <= quorum;
            out_iso_reg    <= iso_reg;
            out_sync_reg   <= sync_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.node_state      = out_state_reg;
    assign result.active_peers    = out_active_reg;
    assign result.synced          = out_synced_reg;
    assign result.quorum_degraded = out_quorum_reg;
    assign result.isolation_count = out_iso_reg;
    assign result.sync_count      = out_sync_reg;

endmodule
